// File: rtl/core/dts_pkg.sv
`default_nettype none
package dts_pkg;

  localparam int QDEPTH = 32;
  localparam int QIW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_TONE  = 2'd1;
  localparam logic [1:0] OP_DIGIT = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic REG_SAMPLE_RATE = 1'b0;
  localparam logic REG_LOOP        = 1'b1;

  typedef struct packed {
    logic [15:0] f1;
    logic [15:0] f2;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [14:0] vol;
  } tone_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad;
    tone_t      tone;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               valid;
    logic [1:0]         status;
    logic               busy;
  } res_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] lo;
    logic [15:0] hi;
  } key_t;

  function automatic key_t key_lookup(input logic [7:0] ch);
    logic [7:0] c;
    key_t k;
    c = (ch >= "A" && ch <= "Z") ? 8'(ch + 8'd32) : ch;
    k.hit = 1'b1;
    k.lo  = 16'd0;
    k.hi  = 16'd0;
    case (c)
      "0": begin k.lo = 16'd941; k.hi = 16'd1336; end
      "1": begin k.lo = 16'd697; k.hi = 16'd1209; end
      "2": begin k.lo = 16'd697; k.hi = 16'd1336; end
      "3": begin k.lo = 16'd697; k.hi = 16'd1477; end
      "4": begin k.lo = 16'd770; k.hi = 16'd1209; end
      "5": begin k.lo = 16'd770; k.hi = 16'd1336; end
      "6": begin k.lo = 16'd770; k.hi = 16'd1477; end
      "7": begin k.lo = 16'd852; k.hi = 16'd1209; end
      "8": begin k.lo = 16'd852; k.hi = 16'd1336; end
      "9": begin k.lo = 16'd852; k.hi = 16'd1477; end
      "a": begin k.lo = 16'd697; k.hi = 16'd1633; end
      "b": begin k.lo = 16'd770; k.hi = 16'd1633; end
      "c": begin k.lo = 16'd852; k.hi = 16'd1633; end
      "d": begin k.lo = 16'd941; k.hi = 16'd1633; end
      "*": begin k.lo = 16'd941; k.hi = 16'd1209; end
      "#": begin k.lo = 16'd941; k.hi = 16'd1477; end
      default: k.hit = 1'b0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dtmf_tone_sequencer_unit.sv
//  channel  | handshake          | fields
//  ---------+--------------------+-----------------------------------------------
//  input    | push / full        | op freq_low freq_high on_time_ms off_time_ms
//           |                    | volume digit_char
//  result   | empty / pop        | sample audio_valid status busy_res
//  config   | wr_en              | wr_index wr_data
//
//  Enqueue and stop words are taken and then delivered by the back end. For each tone
//  visited, a tick reads the tone and turns its on and off times into sample counts by
//  multiply and reciprocal multiply, decides, works out the phase increments at tone
//  start and runs the sine path; zero-length tones add visits. After reset and after
//  each sample_rate write the back end runs the phase-increment divide before it runs
//  a word; input words still queue.
//  A two-word command queue and a two-word result queue let each side stall alone.
`default_nettype none
module dtmf_tone_sequencer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         op,
  input  wire logic [15:0]        freq_low,
  input  wire logic [15:0]        freq_high,
  input  wire logic [15:0]        on_time_ms,
  input  wire logic [15:0]        off_time_ms,
  input  wire logic signed [15:0] volume,
  input  wire logic [7:0]         digit_char,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      sample,
  output logic                    audio_valid,
  output logic [1:0]              status,
  output logic                    busy_res,
  input  wire logic               wr_en,
  input  wire logic               wr_index,
  input  wire logic [17:0]        wr_data
);
  import dts_pkg::*;

  logic [17:0] sample_rate;
  logic        loop_enable;
  logic [17:0] rate_eff;
  logic        rate_wr;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;
  res_t        res;

  assign rate_wr  = wr_en && (wr_index == REG_SAMPLE_RATE);
  assign rate_eff = (sample_rate == 18'd0) ? 18'd1 : sample_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= 18'd8000;
      loop_enable <= 1'b0;
    end else if (wr_en) begin
      if (wr_index == REG_SAMPLE_RATE) sample_rate <= wr_data;
      if (wr_index == REG_LOOP) loop_enable <= wr_data[0];
    end
  end

  dts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .freq_low    (freq_low),
    .freq_high   (freq_high),
    .on_time_ms  (on_time_ms),
    .off_time_ms (off_time_ms),
    .volume      (volume),
    .digit_char  (digit_char),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  dts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rate      (rate_eff),
    .loop_en   (loop_enable),
    .rate_wr   (rate_wr),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign sample      = res.sample;
  assign audio_valid = res.valid;
  assign status      = res.status;
  assign busy_res    = res.busy;

endmodule
`default_nettype wire

// File: rtl/core/dts_front.sv
`default_nettype none
module dts_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        op,
  input  wire logic [15:0]       freq_low,
  input  wire logic [15:0]       freq_high,
  input  wire logic [15:0]       on_time_ms,
  input  wire logic [15:0]       off_time_ms,
  input  wire logic signed [15:0] volume,
  input  wire logic [7:0]        digit_char,
  output logic                   cmd_valid,
  output dts_pkg::cmd_t          cmd,
  input  wire logic              cmd_pop
);
  import dts_pkg::*;

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       cls;
  key_t       key;

  // classify: map digit, normalize volume
  always_comb begin
    key          = key_lookup(digit_char);
    cls.op       = op;
    cls.bad      = 1'b0;
    cls.tone.f1  = freq_low;
    cls.tone.f2  = freq_high;
    cls.tone.on_ms  = on_time_ms;
    cls.tone.off_ms = off_time_ms;
    if (volume == 16'sd0) begin
      cls.tone.vol = 15'd8192;
    end else if (volume[15]) begin
      cls.tone.vol = (volume == 16'sh8000) ? 15'd32767 : 15'(-volume);
    end else begin
      cls.tone.vol = volume[14:0];
    end
    if (op == OP_DIGIT) begin
      if (key.hit) begin
        cls.tone.f1 = key.lo;
        cls.tone.f2 = key.hi;
      end else begin
        cls.bad = 1'b1;
      end
    end
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        q[wp] <= cls;
        wp    <= ~wp;
      end
      if (cmd_pop) rp <= ~rp;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'(cmd_pop ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dts_div.sv
`default_nettype none
module dts_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [33:0] dividend,
  input  wire logic [17:0] divisor,
  output logic             done,
  output logic [33:0]      quot
);
  logic [5:0]  cnt;
  logic [17:0] rem;
  logic [17:0] dvs;
  logic [33:0] dvd;
  logic [18:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, dvd[33]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= (cnt == 6'd1);
      if (start) begin
        cnt <= 6'd34;
        rem <= 18'd0;
        dvd <= dividend;
        dvs <= divisor;
      end else if (cnt != 6'd0) begin
        rem  <= ge ? 18'(rem_sh - {1'b0, dvs}) : rem_sh[17:0];
        dvd  <= {dvd[32:0], 1'b0};
        quot <= {quot[32:0], ge};
        cnt  <= cnt - 6'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dts_back.sv
`default_nettype none
module dts_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [17:0] rate,
  input  wire logic        loop_en,
  input  wire logic        rate_wr,
  input  wire logic        cmd_valid,
  input  dts_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             empty,
  input  wire logic        pop,
  output dts_pkg::res_t    res
);
  import dts_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_QDIV    = 4'd1;
  localparam logic [3:0] S_RD      = 4'd2;
  localparam logic [3:0] S_MUL_ON  = 4'd3;
  localparam logic [3:0] S_DIV_ON  = 4'd4;
  localparam logic [3:0] S_DIV_OFF = 4'd5;
  localparam logic [3:0] S_EVAL    = 4'd6;
  localparam logic [3:0] S_STEPA   = 4'd7;
  localparam logic [3:0] S_STEPB   = 4'd8;
  localparam logic [3:0] S_BODY    = 4'd9;
  localparam logic [3:0] S_SQA     = 4'd10;
  localparam logic [3:0] S_MVA     = 4'd11;
  localparam logic [3:0] S_SQB     = 4'd12;
  localparam logic [3:0] S_MVB     = 4'd13;
  localparam logic [3:0] S_ADDS    = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  // ceil(2^38 / 125): x / 1000 == ((x >> 3) * INV125) >> 38 for any x below 2^34
  localparam logic [31:0] INV125 = 32'd2199023256;

  logic [3:0]  state;
  logic        done_st;
  logic        q_ok, redo;
  logic [31:0] q;
  logic [QCW-1:0] count, guard;
  logic [QIW-1:0] cur;
  logic [QCW-1:0] nxt;
  logic [31:0] pos, phase_a, phase_b, step_a, step_b;
  tone_t       mem [QDEPTH];
  tone_t       tq;
  logic [24:0] on_s;
  logic [25:0] tot;
  logic [31:0] on32, tot32;
  logic        first, made, vld;
  logic [1:0]  stat;
  logic signed [15:0] smp;
  logic [31:0] sq;
  logic signed [31:0] prod_a, prod_b;
  logic [15:0] h, hs;
  logic signed [16:0] sum2;
  logic        div_start, div_done;
  logic [33:0] div_dvd, div_quot;
  logic [33:0] msx;
  logic [63:0] recip_prod;
  logic        is_enq, enq_ok;
  logic        list_end, wrap;

  res_t        rq [2];
  logic        rwp, rrp;
  logic [1:0]  rcnt;

  dts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (rate),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign nxt    = {1'b0, cur} + QCW'(1);
  assign wrap   = (nxt >= count);
  assign on32   = {7'd0, on_s};
  assign tot32  = {6'd0, tot};
  assign h      = sq[30:15];
  assign hs     = (state == S_MVA ? phase_a[31] : phase_b[31]) ? ~h : h;
  assign sum2   = {prod_a[31], prod_a[31:16]} + {prod_b[31], prod_b[31:16]};
  assign is_enq = (cmd.op == OP_TONE) || (cmd.op == OP_DIGIT);
  assign enq_ok = is_enq && !cmd.bad && (count < QCW'(QDEPTH));
  assign list_end = wrap && !loop_en;

  assign cmd_pop = (state == S_IDLE) && !done_st && q_ok && cmd_valid && (rcnt != 2'd2);
  assign empty   = (rcnt == 2'd0);
  assign res     = rq[rrp];

  assign div_dvd    = 34'h0_FFFF_FFFF;
  assign div_start  = (state == S_IDLE) && !done_st && !q_ok;
  assign recip_prod = {33'd0, msx[33:3]} * {32'd0, INV125};

  always_ff @(posedge clk) begin
    if (cmd_pop && enq_ok) mem[count[QIW-1:0]] <= cmd.tone;
    tq <= mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done_st <= 1'b0;
      q_ok    <= 1'b0;
      redo    <= 1'b0;
      count   <= '0;
      cur     <= '0;
      pos     <= 32'd0;
      phase_a <= 32'd0;
      phase_b <= 32'd0;
      step_a  <= 32'd0;
      step_b  <= 32'd0;
      rwp     <= 1'b0;
      rrp     <= 1'b0;
      rcnt    <= 2'd0;
    end else begin
      if (done_st) begin
        // deliver the word and return to idle
        rq[rwp].sample <= smp;
        rq[rwp].valid  <= vld;
        rq[rwp].status <= stat;
        rq[rwp].busy   <= (count != '0);
        rwp     <= ~rwp;
        done_st <= 1'b0;
        state   <= S_IDLE;
      end else begin
        case (state)
          S_IDLE: begin
            if (!q_ok) begin
              redo  <= 1'b0;
              state <= S_QDIV;
            end else if (cmd_pop) begin
              stat <= ST_OK;
              vld  <= 1'b0;
              smp  <= 16'sd0;
              case (cmd.op)
                OP_TONE, OP_DIGIT: begin
                  if (cmd.bad) stat <= ST_BAD;
                  else if (!enq_ok) stat <= ST_FULL;
                  else count <= count + QCW'(1);
                  done_st <= 1'b1;
                end
                OP_STOP: begin
                  count   <= '0;
                  cur     <= '0;
                  pos     <= 32'd0;
                  done_st <= 1'b1;
                end
                default: begin
                  if (count == '0) begin
                    done_st <= 1'b1;
                  end else begin
                    first <= 1'b1;
                    guard <= '0;
                    state <= S_RD;
                  end
                end
              endcase
            end
          end
          S_QDIV: begin
            if (div_done) begin
              q     <= div_quot[31:0];
              q_ok  <= !redo;
              state <= S_IDLE;
            end
          end
          S_RD:     state <= S_MUL_ON;
          S_MUL_ON: begin
            msx   <= {18'd0, tq.on_ms} * {16'd0, rate};
            state <= S_DIV_ON;
          end
          S_DIV_ON: begin
            on_s  <= recip_prod[62:38];
            msx   <= {18'd0, tq.off_ms} * {16'd0, rate};
            state <= S_DIV_OFF;
          end
          S_DIV_OFF: begin
            tot   <= {1'b0, on_s} + {1'b0, recip_prod[62:38]};
            state <= S_EVAL;
          end
          S_EVAL: begin
            first <= 1'b0;
            if (first && pos >= tot32) begin
              // current tone used up on entry: advance first
              pos <= 32'd0;
              if (wrap) cur <= '0;
              else cur <= nxt[QIW-1:0];
              if (list_end) begin
                count   <= '0;
                done_st <= 1'b1;
              end else begin
                vld   <= 1'b1;
                state <= S_RD;
              end
            end else begin
              vld <= 1'b1;
              if (pos == 32'd0) begin
                phase_a <= 32'd0;
                phase_b <= 32'd0;
                state   <= S_STEPA;
              end else begin
                state <= S_BODY;
              end
            end
          end
          S_STEPA: begin
            step_a <= 32'(q * {16'd0, tq.f1});
            state  <= S_STEPB;
          end
          S_STEPB: begin
            step_b <= (tq.f2 != 16'd0) ? 32'(q * {16'd0, tq.f2}) : 32'd0;
            state  <= S_BODY;
          end
          S_BODY: begin
            if (pos < on32) begin
              state <= S_SQA;
            end else if (pos < tot32) begin
              smp   <= 16'sd0;
              pos   <= pos + 32'd1;
              made  <= 1'b1;
              state <= S_FIN;
            end else begin
              made  <= 1'b0;
              state <= S_FIN;
            end
          end
          S_SQA: begin
            sq    <= {16'd0, phase_a[30:15]} * {16'd0, ~phase_a[30:15]};
            state <= S_MVA;
          end
          S_MVA: begin
            prod_a  <= $signed(hs) * $signed({1'b0, tq.vol});
            phase_a <= phase_a + step_a;
            state   <= (tq.f2 != 16'd0) ? S_SQB : S_ADDS;
          end
          S_SQB: begin
            sq    <= {16'd0, phase_b[30:15]} * {16'd0, ~phase_b[30:15]};
            state <= S_MVB;
          end
          S_MVB: begin
            prod_b  <= $signed(hs) * $signed({1'b0, tq.vol});
            phase_b <= phase_b + step_b;
            state   <= S_ADDS;
          end
          S_ADDS: begin
            smp   <= (tq.f2 != 16'd0) ? sum2[16:1] : prod_a[31:16];
            pos   <= pos + 32'd1;
            made  <= 1'b1;
            state <= S_FIN;
          end
          S_FIN: begin
            if (pos == tot32) begin
              pos <= 32'd0;
              if (wrap) cur <= '0;
              else cur <= nxt[QIW-1:0];
            end
            if (pos == tot32 && list_end) begin
              count   <= '0;
              done_st <= 1'b1;
            end else if (made || guard == QCW'(QDEPTH)) begin
              done_st <= 1'b1;
            end else begin
              guard <= guard + QCW'(1);
              state <= S_RD;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
      if (pop && !empty) rrp <= ~rrp;
      rcnt <= rcnt + 2'(done_st ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      if (rate_wr) begin
        q_ok <= 1'b0;
        redo <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("tone count past queue depth");
  a_cur_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count != '0) |-> ({1'b0, cur} < count))
    else $error("current tone outside list");
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    done_st |-> (rcnt != 2'd2))
    else $error("result word pushed into full queue");
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (done_st || state == S_RD))
    else $error("command taken but not started");
`endif

endmodule
`default_nettype wire
